@@ hdl/cte_pkg.sv @@
// ----------------------------------------------------------------------------
// cte_pkg: shared codes for the capability table engine
// Operation, event and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package cte_pkg;

    // parameter defaults
    localparam int SLOTS_DEF       = 16;
    localparam int TASKS_DEF       = 4;
    localparam int OBJECT_BITS_DEF = 16;

    // at most this many events per transaction
    localparam logic [5:0] MAX_EVENTS = 6'd63;

    // operation codes
    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_INSERT = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_DELETE = 3'd3,
        OP_DERIVE = 3'd4,
        OP_GRANT  = 3'd5,
        OP_REVOKE = 3'd6,
        OP_BAD    = 3'd7
    } t_op;

    // result item kinds
    typedef enum logic [1:0] {
        EV_STATUS  = 2'd0,
        EV_RETAIN  = 2'd1,
        EV_RELEASE = 2'd2
    } t_ev;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_SRC_EMPTY = 3'd2,
        ST_RIGHTS    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // kind code of an empty entry
    localparam logic [2:0] KIND_NULL = 3'd0;

endpackage

@@ hdl/capability_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// capability_table_engine_core: per-task capability tables
// Sequenced table engine with one read and one write port on the entry store.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_in_valid / o_in_ready) carries one operation per
// transaction. The result channel (o_out_valid / i_out_ready) returns zero
// or more retain/release events followed by one final status item with
// o_last high. o_in_ready is high only while the sequencer is idle, so one
// operation is in flight at a time.
// Sequencer path per operation: alloc and requests rejected at decode go
// straight to the final status; lookup, delete, and copies refused for an
// empty source or excess rights read the source entry, then check it;
// insert and a copy onto its own source entry then also write the entry; a
// copy to another entry reads and checks the target entry before the write.
// A revoke of an empty or objectless entry ends after the check; a full
// revoke reads then checks each of the DEPTH entries (64 by default), where
// DEPTH = 2^(clog2(TASKS) + clog2(SLOTS)), with at least one task bit.
// Reset empties every table at once through the per-entry occupancy bits;
// entry contents are not cleared. Events do not hold up the sequencer while
// the receiver keeps up; when it stalls, the pending result stays in the
// output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module capability_table_engine_core
    import cte_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int TASKS       = TASKS_DEF,
    parameter int OBJECT_BITS = OBJECT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [1:0]  i_act_task,
    input  logic [1:0]  i_tgt_task,
    input  logic [7:0]  i_act_slot,
    input  logic [7:0]  i_tgt_slot,
    input  logic [2:0]  i_cap_kind_in,
    input  logic [15:0] i_object_in,
    input  logic [2:0]  i_rights_in,
    input  logic [31:0] i_badge_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [2:0]  o_status,
    output logic [1:0]  o_task_out,
    output logic [3:0]  o_slot_out,
    output logic [2:0]  o_cap_kind_out,
    output logic [15:0] o_object_out,
    output logic [2:0]  o_rights_out,
    output logic [31:0] o_badge_out,
    output logic        o_last
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TASK_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int IDX_W  = SLOT_W + TASK_W;
    localparam int DEPTH  = 1 << IDX_W;
    localparam int OBJ_W  = (OBJECT_BITS < 16) ? OBJECT_BITS : 16;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_RD      = 9'b000000010,
        S_EV      = 9'b000000100,
        S_RD2     = 9'b000001000,
        S_EV2     = 9'b000010000,
        S_PUT     = 9'b000100000,
        S_SCAN_RD = 9'b001000000,
        S_SCAN_EV = 9'b010000000,
        S_FIN     = 9'b100000000
    } t_state;

    // entry store
    logic [2:0]       mem_kind   [DEPTH];
    logic [OBJ_W-1:0] mem_obj    [DEPTH];
    logic [2:0]       mem_rights [DEPTH];
    logic [31:0]      mem_badge  [DEPTH];
    logic [DEPTH-1:0] r_occ;

    logic [2:0]       r_rd_kind;
    logic [OBJ_W-1:0] r_rd_obj;
    logic [2:0]       r_rd_rights;
    logic [31:0]      r_rd_badge;
    logic             r_rd_vld;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [IDX_W-1:0] r_src_idx, n_src_idx;
    logic [IDX_W-1:0] r_dst_idx, n_dst_idx;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic [5:0]       r_evcnt, n_evcnt;
    logic             r_inplace, n_inplace;
    logic [2:0]       r_kind, n_kind;
    logic [OBJ_W-1:0] r_obj, n_obj;
    logic [2:0]       r_rights, n_rights;
    logic [31:0]      r_badge, n_badge;
    t_status          r_status, n_status;
    logic [1:0]       r_ftask, n_ftask;
    logic [3:0]       r_fslot, n_fslot;
    logic [2:0]       r_fk, n_fk;
    logic [OBJ_W-1:0] r_fo, n_fo;
    logic [2:0]       r_fr, n_fr;
    logic [31:0]      r_fb, n_fb;

    logic             r_out_vld, n_out_vld;
    t_ev              r_out_ev, n_out_ev;
    t_status          r_out_st, n_out_st;
    logic [1:0]       r_out_task, n_out_task;
    logic [3:0]       r_out_slot, n_out_slot;
    logic [2:0]       r_out_kind, n_out_kind;
    logic [OBJ_W-1:0] r_out_obj, n_out_obj;
    logic [2:0]       r_out_rights, n_out_rights;
    logic [31:0]      r_out_badge, n_out_badge;
    logic             r_out_last, n_out_last;

    logic             out_free;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic             occ_set, occ_clr;
    logic [IDX_W-1:0] occ_idx;

    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // read address select, held while a state waits on the output register
    always_comb begin
        if ((r_state == S_RD2) || (r_state == S_EV2)) begin
            rd_addr = r_dst_idx;
        end else if ((r_state == S_SCAN_RD) || (r_state == S_SCAN_EV)) begin
            rd_addr = r_scan;
        end else begin
            rd_addr = r_src_idx;
        end
    end

    // sequencer
    always_comb begin
        logic             task_ok, slot_ok, tt_ok, ds_ok, found;
        logic [1:0]       tt;
        logic [SLOT_W-1:0] free_slot;
        logic [OBJ_W-1:0] oin;
        logic             match, need_ev;
        t_op              op_in;

        n_state = r_state;   n_op = r_op;           n_src_idx = r_src_idx;
        n_dst_idx = r_dst_idx; n_scan = r_scan;     n_evcnt = r_evcnt;
        n_inplace = r_inplace; n_kind = r_kind;     n_obj = r_obj;
        n_rights = r_rights; n_badge = r_badge;     n_status = r_status;
        n_ftask = r_ftask;   n_fslot = r_fslot;     n_fk = r_fk;
        n_fo = r_fo;         n_fr = r_fr;           n_fb = r_fb;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out_ev = r_out_ev; n_out_st = r_out_st;   n_out_task = r_out_task;
        n_out_slot = r_out_slot; n_out_kind = r_out_kind; n_out_obj = r_out_obj;
        n_out_rights = r_out_rights; n_out_badge = r_out_badge;
        n_out_last = r_out_last;
        mem_we = 1'b0; occ_set = 1'b0; occ_clr = 1'b0; occ_idx = r_dst_idx;

        op_in   = t_op'(i_op);
        task_ok = (32'(i_act_task) < TASKS);
        slot_ok = (32'(i_act_slot) < SLOTS);
        tt      = (op_in == OP_DERIVE) ? i_act_task : i_tgt_task;
        tt_ok   = (32'(tt) < TASKS);
        ds_ok   = (32'(i_tgt_slot) < SLOTS);
        oin     = OBJ_W'(i_object_in & 16'((33'd1 << OBJECT_BITS) - 33'd1));

        // lowest free slot of the addressed task
        found = 1'b0;
        free_slot = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_occ[{i_act_task[TASK_W-1:0], SLOT_W'(s)}]) begin
                found = 1'b1;
                free_slot = SLOT_W'(s);
            end
        end

        match   = (r_scan != r_src_idx) && r_rd_vld && (r_rd_obj == r_obj);
        need_ev = match && (r_evcnt != MAX_EVENTS);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = op_in;
                    n_src_idx = {i_act_task[TASK_W-1:0], i_act_slot[SLOT_W-1:0]};
                    n_dst_idx = {i_act_task[TASK_W-1:0], i_act_slot[SLOT_W-1:0]};
                    n_evcnt   = '0;
                    n_inplace = 1'b0;
                    n_kind    = i_cap_kind_in;
                    n_obj     = oin;
                    n_rights  = i_rights_in;
                    n_badge   = i_badge_in;
                    n_status  = ST_OK;
                    n_ftask   = i_act_task;
                    n_fslot   = i_act_slot[3:0];
                    n_fk = '0; n_fo = '0; n_fr = '0; n_fb = '0;
                    n_state   = S_FIN;
                    unique case (op_in)
                        OP_ALLOC: begin
                            n_fslot = '0;
                            if (!task_ok) begin
                                n_status = ST_INVALID;
                            end else if (!found) begin
                                n_status = ST_FULL;
                            end else begin
                                n_fslot = 4'(free_slot);
                            end
                        end
                        OP_INSERT: begin
                            if (!task_ok || !slot_ok || i_cap_kind_in == KIND_NULL) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_LOOKUP, OP_DELETE, OP_REVOKE: begin
                            if (!task_ok || !slot_ok) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_DERIVE, OP_GRANT: begin
                            n_ftask   = tt;
                            n_fslot   = i_tgt_slot[3:0];
                            n_dst_idx = {tt[TASK_W-1:0], i_tgt_slot[SLOT_W-1:0]};
                            if (!task_ok || !tt_ok || !slot_ok || !ds_ok) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: n_status = ST_INVALID;
                    endcase
                end
            end
            S_RD:  n_state = S_EV;
            S_RD2: n_state = S_EV2;
            S_EV: begin
                case (r_op)
                    OP_INSERT, OP_DELETE: begin
                        if (!r_rd_vld || r_rd_obj == '0 || out_free) begin
                            if (r_rd_vld && r_rd_obj != '0) begin
                                n_out_vld = 1'b1; n_out_ev = EV_RELEASE;
                                n_out_st = ST_OK; n_out_task = r_ftask;
                                n_out_slot = r_fslot; n_out_kind = r_rd_kind;
                                n_out_obj = r_rd_obj; n_out_rights = '0;
                                n_out_badge = '0; n_out_last = 1'b0;
                            end
                            if (r_op == OP_INSERT) begin
                                n_state = S_PUT;
                            end else begin
                                occ_clr = 1'b1;
                                occ_idx = r_src_idx;
                                n_state = S_FIN;
                            end
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_rd_vld) begin
                            n_fk = r_rd_kind; n_fo = r_rd_obj;
                            n_fr = r_rd_rights; n_fb = r_rd_badge;
                        end else begin
                            n_status = ST_SRC_EMPTY;
                        end
                        n_state = S_FIN;
                    end
                    OP_DERIVE, OP_GRANT: begin
                        n_state = S_FIN;
                        if (!r_rd_vld) begin
                            n_status = ST_SRC_EMPTY;
                        end else if ((r_rights & ~r_rd_rights) != 3'd0) begin
                            n_status = ST_RIGHTS;
                        end else begin
                            n_kind = r_rd_kind;
                            n_obj  = r_rd_obj;
                            if (r_op == OP_DERIVE) begin
                                n_badge = r_rd_badge;
                            end
                            if (r_src_idx == r_dst_idx) begin
                                n_inplace = 1'b1;
                                n_state   = S_PUT;
                            end else begin
                                n_state = S_RD2;
                            end
                        end
                    end
                    OP_REVOKE: begin
                        if (!r_rd_vld || r_rd_obj == '0) begin
                            n_status = ST_SRC_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_obj   = r_rd_obj;
                            n_scan  = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_EV2: begin
                if (!r_rd_vld || r_rd_obj == '0 || out_free) begin
                    if (r_rd_vld && r_rd_obj != '0) begin
                        n_out_vld = 1'b1; n_out_ev = EV_RELEASE;
                        n_out_st = ST_OK; n_out_task = r_ftask;
                        n_out_slot = r_fslot; n_out_kind = r_rd_kind;
                        n_out_obj = r_rd_obj; n_out_rights = '0;
                        n_out_badge = '0; n_out_last = 1'b0;
                    end
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (r_inplace || r_obj == '0 || out_free) begin
                    mem_we  = 1'b1;
                    occ_set = 1'b1;
                    occ_idx = r_dst_idx;
                    if (!r_inplace && r_obj != '0) begin
                        n_out_vld = 1'b1; n_out_ev = EV_RETAIN;
                        n_out_st = ST_OK; n_out_task = r_ftask;
                        n_out_slot = r_fslot; n_out_kind = r_kind;
                        n_out_obj = r_obj; n_out_rights = '0;
                        n_out_badge = '0; n_out_last = 1'b0;
                    end
                    n_state = S_FIN;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (!need_ev || out_free) begin
                    if (match) begin
                        occ_clr = 1'b1;
                        occ_idx = r_scan;
                    end
                    if (need_ev) begin
                        n_evcnt = r_evcnt + 6'd1;
                        n_out_vld = 1'b1; n_out_ev = EV_RELEASE;
                        n_out_st = ST_OK;
                        n_out_task = 2'(r_scan[IDX_W-1:SLOT_W]);
                        n_out_slot = 4'(r_scan[SLOT_W-1:0]);
                        n_out_kind = r_rd_kind; n_out_obj = r_rd_obj;
                        n_out_rights = '0; n_out_badge = '0; n_out_last = 1'b0;
                    end
                    if (r_scan == IDX_W'(DEPTH - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_scan  = r_scan + IDX_W'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld = 1'b1; n_out_ev = EV_STATUS;
                    n_out_st = r_status; n_out_task = r_ftask;
                    n_out_slot = r_fslot; n_out_kind = r_fk;
                    n_out_obj = r_fo; n_out_rights = r_fr;
                    n_out_badge = r_fb; n_out_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_kind[r_dst_idx]   <= r_kind;
            mem_obj[r_dst_idx]    <= r_obj;
            mem_rights[r_dst_idx] <= r_rights;
            mem_badge[r_dst_idx]  <= r_badge;
        end
        r_rd_kind   <= mem_kind[rd_addr];
        r_rd_obj    <= mem_obj[rd_addr];
        r_rd_rights <= mem_rights[rd_addr];
        r_rd_badge  <= mem_badge[rd_addr];
        r_rd_vld    <= r_occ[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_occ     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (occ_set) begin
                r_occ[occ_idx] <= 1'b1;
            end else if (occ_clr) begin
                r_occ[occ_idx] <= 1'b0;
            end
        end
    end

    // operation context and output register
    always_ff @(posedge i_clk) begin
        r_op <= n_op;         r_src_idx <= n_src_idx; r_dst_idx <= n_dst_idx;
        r_scan <= n_scan;     r_evcnt <= n_evcnt;     r_inplace <= n_inplace;
        r_kind <= n_kind;     r_obj <= n_obj;         r_rights <= n_rights;
        r_badge <= n_badge;   r_status <= n_status;   r_ftask <= n_ftask;
        r_fslot <= n_fslot;   r_fk <= n_fk;           r_fo <= n_fo;
        r_fr <= n_fr;         r_fb <= n_fb;
        r_out_ev <= n_out_ev; r_out_st <= n_out_st;   r_out_task <= n_out_task;
        r_out_slot <= n_out_slot; r_out_kind <= n_out_kind;
        r_out_obj <= n_out_obj;   r_out_rights <= n_out_rights;
        r_out_badge <= n_out_badge; r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_vld;
    assign o_event_res    = r_out_ev;
    assign o_status       = r_out_st;
    assign o_task_out     = r_out_task;
    assign o_slot_out     = r_out_slot;
    assign o_cap_kind_out = r_out_kind;
    assign o_object_out   = 16'(r_out_obj);
    assign o_rights_out   = r_out_rights;
    assign o_badge_out    = r_out_badge;
    assign o_last         = r_out_last;

    // busy after an accepted request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while engine busy");

    // a pending event means the operation is still running
    a_event_mid_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> (r_state != S_IDLE))
        else $error("event pending with sequencer idle");

    // the table scan belongs to revoke only
    a_scan_revoke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN_EV) || (r_state == S_SCAN_RD)) |-> (r_op == OP_REVOKE))
        else $error("table scan outside revoke");

endmodule

@@ tb/sv/capability_table_engine_core_test.sv @@
// ----------------------------------------------------------------------------
// capability_table_engine_core_test: self-checking bench for the table engine
// Walks a short table of directed operations, then a few hundred random ones
// (fill bursts, revokes over a small object pool, noise), with random idling on
// both channels, and checks every result transaction against a predictor.
// ----------------------------------------------------------------------------
module capability_table_engine_core_test;
    import cte_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NTASK = TASKS_DEF;
    localparam int NENT  = NSLOT * NTASK;
    localparam int RANDOM_ITEMS = 375;

    typedef struct {
        t_op         op;
        logic [1:0]  act_task;
        logic [1:0]  tgt_task;
        logic [7:0]  act_slot;
        logic [7:0]  tgt_slot;
        logic [2:0]  kind;
        logic [15:0] obj;
        logic [2:0]  rights;
        logic [31:0] badge;
    } t_op_item;

    typedef struct {
        logic [1:0]  ev;
        logic [2:0]  st;
        logic [1:0]  tsk;
        logic [3:0]  slot;
        logic [2:0]  kind;
        logic [15:0] obj;
        logic [2:0]  rights;
        logic [31:0] badge;
        logic        last;
    } t_cap_result;

    typedef struct {
        t_op_item item;
        bit       has_status;
        t_status  status;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_op;
    logic [1:0]  i_act_task;
    logic [1:0]  i_tgt_task;
    logic [7:0]  i_act_slot;
    logic [7:0]  i_tgt_slot;
    logic [2:0]  i_cap_kind_in;
    logic [15:0] i_object_in;
    logic [2:0]  i_rights_in;
    logic [31:0] i_badge_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_event_res;
    logic [2:0]  o_status;
    logic [1:0]  o_task_out;
    logic [3:0]  o_slot_out;
    logic [2:0]  o_cap_kind_out;
    logic [15:0] o_object_out;
    logic [2:0]  o_rights_out;
    logic [31:0] o_badge_out;
    logic        o_last;

    // shadow capability tables
    logic [2:0]  cap_kind   [NENT];
    logic [15:0] cap_object [NENT];
    logic [2:0]  cap_rights [NENT];
    logic [31:0] cap_badge  [NENT];
    int          event_count;

    t_cap_result expected_results[$];
    t_dir_row    dir_rows[$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          revokes_sent;
    int          full_seen;
    bit          idling_on;

    capability_table_engine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_act_task(i_act_task), .i_tgt_task(i_tgt_task),
        .i_act_slot(i_act_slot), .i_tgt_slot(i_tgt_slot),
        .i_cap_kind_in(i_cap_kind_in), .i_object_in(i_object_in),
        .i_rights_in(i_rights_in), .i_badge_in(i_badge_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_event_res(o_event_res), .o_status(o_status),
        .o_task_out(o_task_out), .o_slot_out(o_slot_out),
        .o_cap_kind_out(o_cap_kind_out), .o_object_out(o_object_out),
        .o_rights_out(o_rights_out), .o_badge_out(o_badge_out),
        .o_last(o_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // mismatch reporting
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)",
                 what, got, want, results_seen);
        errors++;
    endtask

    // ---------------- predictor ----------------
    function automatic void push_result(logic [1:0] ev, logic [2:0] st,
                                        logic [1:0] t, logic [3:0] s,
                                        logic [2:0] k, logic [15:0] o,
                                        logic [2:0] r, logic [31:0] b,
                                        logic lst);
        t_cap_result res;
        res = '{ev, st, t, s, k, o, r, b, lst};
        expected_results.push_back(res);
    endfunction

    // retain or release event, skipped for object zero and past the cap
    function automatic void add_event(t_ev ev, int t, int s, logic [2:0] k,
                                      logic [15:0] o);
        if (o == 16'd0 || event_count >= int'(MAX_EVENTS))
            return;
        event_count++;
        push_result(ev, ST_OK, t[1:0], s[3:0], k, o, 3'd0, 32'd0, 1'b0);
    endfunction

    function automatic void clear_entry(int t, int s);
        int i;
        i = t * NSLOT + s;
        if (cap_kind[i] != KIND_NULL)
            add_event(EV_RELEASE, t, s, cap_kind[i], cap_object[i]);
        cap_kind[i]   = KIND_NULL;
        cap_object[i] = '0;
        cap_rights[i] = '0;
        cap_badge[i]  = '0;
    endfunction

    function automatic void predict_op(t_op_item it);
        t_status     status;
        logic [1:0]  ftask;
        logic [7:0]  fslot;
        logic [2:0]  fk, fr;
        logic [15:0] fo;
        logic [31:0] fb, bdg;
        int          st, tt, ss, ds, si, di;
        bit          task_ok, slot_ok;
        logic [2:0]  k;
        logic [15:0] o;
        status = ST_OK;
        ftask = it.act_task;
        fslot = it.act_slot;
        fk = '0; fo = '0; fr = '0; fb = '0;
        st = int'(it.act_task);
        ss = int'(it.act_slot);
        ds = int'(it.tgt_slot);
        task_ok = st < NTASK;
        slot_ok = ss < NSLOT;
        event_count = 0;
        case (it.op)
            OP_ALLOC: begin
                fslot = '0;
                if (!task_ok) begin
                    status = ST_INVALID;
                end else begin
                    status = ST_FULL;
                    for (int s = NSLOT - 1; s >= 0; s--)
                        if (cap_kind[st * NSLOT + s] == KIND_NULL) begin
                            status = ST_OK;
                            fslot = s[7:0];
                        end
                end
            end
            OP_INSERT: begin
                if (!task_ok || !slot_ok || it.kind == KIND_NULL) begin
                    status = ST_INVALID;
                end else begin
                    si = st * NSLOT + ss;
                    clear_entry(st, ss);
                    cap_kind[si]   = it.kind;
                    cap_object[si] = it.obj;
                    cap_rights[si] = it.rights;
                    cap_badge[si]  = it.badge;
                    add_event(EV_RETAIN, st, ss, it.kind, it.obj);
                end
            end
            OP_LOOKUP: begin
                if (!task_ok || !slot_ok) begin
                    status = ST_INVALID;
                end else begin
                    si = st * NSLOT + ss;
                    if (cap_kind[si] == KIND_NULL) begin
                        status = ST_SRC_EMPTY;
                    end else begin
                        fk = cap_kind[si];
                        fo = cap_object[si];
                        fr = cap_rights[si];
                        fb = cap_badge[si];
                    end
                end
            end
            OP_DELETE: begin
                if (!task_ok || !slot_ok)
                    status = ST_INVALID;
                else
                    clear_entry(st, ss);
            end
            OP_DERIVE, OP_GRANT: begin
                tt = (it.op == OP_DERIVE) ? st : int'(it.tgt_task);
                ftask = tt[1:0];
                fslot = it.tgt_slot;
                if (!task_ok || tt >= NTASK || !slot_ok || ds >= NSLOT) begin
                    status = ST_INVALID;
                end else begin
                    si = st * NSLOT + ss;
                    di = tt * NSLOT + ds;
                    if (cap_kind[si] == KIND_NULL) begin
                        status = ST_SRC_EMPTY;
                    end else if ((it.rights & ~cap_rights[si]) != 3'd0) begin
                        status = ST_RIGHTS;
                    end else begin
                        bdg = (it.op == OP_DERIVE) ? cap_badge[si] : it.badge;
                        if (si == di) begin
                            // restrict in place, no events
                            cap_rights[di] = it.rights;
                            cap_badge[di]  = bdg;
                        end else begin
                            k = cap_kind[si];
                            o = cap_object[si];
                            clear_entry(tt, ds);
                            cap_kind[di]   = k;
                            cap_object[di] = o;
                            cap_rights[di] = it.rights;
                            cap_badge[di]  = bdg;
                            add_event(EV_RETAIN, tt, ds, k, o);
                        end
                    end
                end
            end
            OP_REVOKE: begin
                if (!task_ok || !slot_ok) begin
                    status = ST_INVALID;
                end else begin
                    si = st * NSLOT + ss;
                    if (cap_kind[si] == KIND_NULL || cap_object[si] == 16'd0) begin
                        status = ST_SRC_EMPTY;
                    end else begin
                        o = cap_object[si];
                        for (int i = 0; i < NENT; i++)
                            if (i != si && cap_kind[i] != KIND_NULL && cap_object[i] == o)
                                clear_entry(i / NSLOT, i % NSLOT);
                    end
                end
            end
            default: status = ST_INVALID;
        endcase
        if (status == ST_FULL)
            full_seen++;
        push_result(EV_STATUS, status, ftask, fslot[3:0], fk, fo, fr, fb, 1'b1);
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_op_item mk(t_op op, int st, int dt, int ss, int ds,
                                    int k, logic [15:0] o, int r,
                                    logic [31:0] b);
        t_op_item it;
        it = '{op, st[1:0], dt[1:0], ss[7:0], ds[7:0], k[2:0], o, r[2:0], b};
        return it;
    endfunction

    function automatic void add_row(t_op_item it, bit chk, t_status s);
        t_dir_row row;
        row = '{it, chk, s};
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] rand_slot();
        if ($urandom_range(99) < 90)
            return 8'($urandom_range(NSLOT - 1));
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_object();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(6, 1));
        if (r < 80)
            return 16'd0;
        return 16'($urandom);
    endfunction

    function automatic t_op_item rand_item();
        t_op_item it;
        int       w;
        w = $urandom_range(99);
        if (w < 8)       it.op = OP_ALLOC;
        else if (w < 35) it.op = OP_INSERT;
        else if (w < 47) it.op = OP_LOOKUP;
        else if (w < 57) it.op = OP_DELETE;
        else if (w < 71) it.op = OP_DERIVE;
        else if (w < 85) it.op = OP_GRANT;
        else if (w < 97) it.op = OP_REVOKE;
        else             it.op = OP_BAD;
        it.act_task = 2'($urandom);
        it.tgt_task = 2'($urandom);
        it.act_slot = rand_slot();
        it.tgt_slot = rand_slot();
        it.kind     = ($urandom_range(99) < 90) ? 3'($urandom_range(7, 1)) : KIND_NULL;
        it.obj      = rand_object();
        it.rights   = 3'($urandom);
        it.badge    = $urandom;
        return it;
    endfunction

    // send one operation, update the prediction on acceptance
    task automatic send_op(input t_op_item it, input bit chk, input t_status s);
        @(negedge i_clk);
        while (idling_on && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_act_task    <= it.act_task;
        i_tgt_task    <= it.tgt_task;
        i_act_slot    <= it.act_slot;
        i_tgt_slot    <= it.tgt_slot;
        i_cap_kind_in <= it.kind;
        i_object_in   <= it.obj;
        i_rights_in   <= it.rights;
        i_badge_in    <= it.badge;
        do @(posedge i_clk); while (!o_in_ready);
        predict_op(it);
        if (chk)
            expected_results[$].st = s;
        items_sent++;
        if (it.op == OP_REVOKE)
            revokes_sent++;
    endtask

    // receiver back-pressure
    always @(negedge i_clk)
        i_out_ready <= (idling_on && $urandom_range(99) < 17) ? 1'b0 : 1'b1;

    // result checking
    always @(posedge i_clk) begin
        t_cap_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {30'd0, o_event_res}, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_event_res != want.ev)
                    report_mismatch("event", 32'(o_event_res), 32'(want.ev));
                if (o_status != want.st)
                    report_mismatch("status", 32'(o_status), 32'(want.st));
                if (o_task_out != want.tsk)
                    report_mismatch("task", 32'(o_task_out), 32'(want.tsk));
                if (o_slot_out != want.slot)
                    report_mismatch("slot", 32'(o_slot_out), 32'(want.slot));
                if (o_cap_kind_out != want.kind)
                    report_mismatch("kind", 32'(o_cap_kind_out), 32'(want.kind));
                if (o_object_out != want.obj)
                    report_mismatch("object", 32'(o_object_out), 32'(want.obj));
                if (o_rights_out != want.rights)
                    report_mismatch("rights", 32'(o_rights_out), 32'(want.rights));
                if (o_badge_out != want.badge)
                    report_mismatch("badge", o_badge_out, want.badge);
                if (o_last != want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // overall time limit
    initial begin
        #(12 * 3000000);
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial begin
        int       fill_task;
        t_op_item it;
        bit       drained;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_ALLOC;
        i_act_task = '0; i_tgt_task = '0; i_act_slot = '0; i_tgt_slot = '0;
        i_cap_kind_in = '0; i_object_in = '0; i_rights_in = '0; i_badge_in = '0;
        errors = 0; items_sent = 0; results_seen = 0; revokes_sent = 0;
        full_seen = 0; idling_on = 1'b1; drained = 1'b0;
        for (int i = 0; i < NENT; i++) begin
            cap_kind[i] = KIND_NULL; cap_object[i] = '0;
            cap_rights[i] = '0; cap_badge[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        add_row(mk(OP_ALLOC,  0, 0, 0, 0, 0, 16'h0, 0, 32'h0), 1, ST_OK);
        add_row(mk(OP_LOOKUP, 0, 0, 0, 0, 0, 16'h0, 0, 32'h0), 1, ST_SRC_EMPTY);
        add_row(mk(OP_DELETE, 0, 0, 0, 0, 0, 16'h0, 0, 32'h0), 1, ST_OK);
        add_row(mk(OP_INSERT, 0, 0, 0, 0, 0, 16'h5, 7, 32'h1), 1, ST_INVALID);
        add_row(mk(OP_INSERT, 0, 0, 16, 0, 1, 16'h5, 7, 32'h1), 1, ST_INVALID);
        add_row(mk(OP_INSERT, 3, 3, 255, 255, 7, 16'hFFFF, 7, 32'hFFFFFFFF),
                1, ST_INVALID);
        add_row(mk(OP_INSERT, 0, 0, 0, 0, 1, 16'hFFFF, 7, 32'hFFFFFFFF), 1, ST_OK);
        add_row(mk(OP_INSERT, 0, 0, 0, 0, 7, 16'hFFFF, 7, 32'h0), 1, ST_OK);
        add_row(mk(OP_LOOKUP, 0, 0, 0, 0, 0, 16'h0, 0, 32'h0), 1, ST_OK);
        add_row(mk(OP_INSERT, 0, 0, 1, 0, 2, 16'h1234, 1, 32'h5), 1, ST_OK);
        add_row(mk(OP_DERIVE, 0, 0, 1, 2, 0, 16'h0, 3, 32'h0), 1, ST_RIGHTS);
        add_row(mk(OP_DERIVE, 0, 0, 0, 2, 0, 16'h0, 3, 32'h0), 1, ST_OK);
        add_row(mk(OP_GRANT, 0, 3, 0, 15, 0, 16'h0, 4, 32'hAAAAAAAA), 1, ST_OK);
        // copies onto the source entry restrict it in place
        add_row(mk(OP_DERIVE, 0, 0, 2, 2, 0, 16'h0, 1, 32'h0), 0, ST_OK);
        add_row(mk(OP_GRANT, 0, 0, 2, 2, 0, 16'h0, 1, 32'h55555555), 0, ST_OK);
        add_row(mk(OP_LOOKUP, 0, 0, 2, 0, 0, 16'h0, 0, 32'h0), 0, ST_OK);
        // object zero: no events, revoke refused
        add_row(mk(OP_INSERT, 1, 0, 3, 0, 3, 16'h0, 7, 32'h9), 1, ST_OK);
        add_row(mk(OP_REVOKE, 1, 0, 3, 0, 0, 16'h0, 0, 32'h0), 1, ST_SRC_EMPTY);
        add_row(mk(OP_REVOKE, 0, 0, 0, 0, 0, 16'h0, 0, 32'h0), 1, ST_OK);
        add_row(mk(OP_LOOKUP, 3, 0, 15, 0, 0, 16'h0, 0, 32'h0), 1, ST_SRC_EMPTY);
        add_row(mk(OP_BAD, 0, 0, 0, 0, 0, 16'h0, 0, 32'h0), 1, ST_INVALID);
        add_row(mk(OP_DERIVE, 0, 0, 5, 6, 0, 16'h0, 0, 32'h0), 1, ST_SRC_EMPTY);
        add_row(mk(OP_GRANT, 0, 2, 0, 99, 0, 16'h0, 0, 32'h0), 1, ST_INVALID);
        add_row(mk(OP_LOOKUP, 2, 0, 200, 0, 0, 16'h0, 0, 32'h0), 1, ST_INVALID);
        add_row(mk(OP_DELETE, 0, 0, 1, 0, 0, 16'h0, 0, 32'h0), 1, ST_OK);
        foreach (dir_rows[i])
            send_op(dir_rows[i].item, dir_rows[i].has_status, dir_rows[i].status);

        // random part: fill bursts, single operations, one quiet stretch
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            if (n >= 120 && n < 200)
                idling_on = 1'b0;
            else
                idling_on = 1'b1;
            if (!drained && n >= 250) begin
                // hold the sender until the engine has drained
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait (expected_results.size() == 0);
                drained = 1'b1;
            end
            if ($urandom_range(99) < 6) begin
                fill_task = $urandom_range(NTASK - 1);
                for (int s = 0; s < NSLOT; s++) begin
                    it = mk(OP_INSERT, fill_task, 0, s, 0, $urandom_range(7, 1),
                            rand_object(), $urandom_range(7), $urandom);
                    send_op(it, 0, ST_OK);
                end
                send_op(mk(OP_ALLOC, fill_task, 0, 0, 0, 0, 16'h0, 0, 32'h0), 0, ST_OK);
                n += NSLOT + 1;
            end else begin
                send_op(rand_item(), 0, ST_OK);
                n++;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (300) @(posedge i_clk);

        $display("ran %0d operations (%0d revokes, %0d full-table allocs), %0d results",
                 items_sent, revokes_sent, full_seen, results_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
